FILE: rtl/terminal_line_editor_defines.svh
// Assertion macros used by the line editor back end.
`ifndef TERMINAL_LINE_EDITOR_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define TLE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define TLE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/tle_pkg.sv
package tle_pkg;

  localparam int LINE_MAX = 32;
  localparam int IDX_W    = $clog2(LINE_MAX);
  localparam int LEN_W    = 5;
  localparam int CFG_W    = 6;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [CFG_W-1:0] CAP_RESET = 6'd32;
  localparam logic             REG_LINE_CAPACITY = 1'b0;

  localparam logic [7:0] CH_CTRLC = 8'h03;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_UC_C  = 8'h43;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  typedef enum logic [1:0] {
    EV_BYTE = 2'd0,
    EV_EOF  = 2'd1,
    EV_ERR  = 2'd2,
    EV_NONE = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    K_ECHO  = 3'd0,
    K_CHAR  = 3'd1,
    K_DONE  = 3'd2,
    K_INTR  = 3'd3,
    K_EMPTY = 3'd4,
    K_FAIL  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    OP_ECHO  = 3'd0,
    OP_ERASE = 3'd1,
    OP_INTR  = 3'd2,
    OP_FAIL  = 3'd3,
    OP_EMPTY = 3'd4,
    OP_DUMP  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_RUN  = 2'd1,
    B_CHAR = 2'd2,
    B_DONE = 2'd3
  } bstate_t;

  typedef struct packed {
    op_t              op;
    logic             nl;
    logic [7:0]       data;
    logic [IDX_W-1:0] len;
  } cmd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } wr_req_t;

endpackage

FILE: rtl/terminal_line_editor.sv
// Channel  | Direction | Payload
// in_      | slave     | tdata: rx_byte; tuser: event_req
// out_     | master    | tdata: data_byte, line_length; tuser: kind; tlast: last
// cfg_     | APB       | line_capacity at byte address 0
//
// A single-beat item is written to the command queue, popped into the sequencer,
// then loaded into the output register, where its beat becomes valid.
// Erase gives 3 beats, interrupt 4, line end 1 + fill + 1 (no echo beat on end of
// input), one beat per cycle after the pop while out_tready stays high.
// Input is held off from a line-end beat until its done beat is loaded, and while
// the four-entry command queue is full. Reset is synchronous; no clearing pass.

module terminal_line_editor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // rx_byte [7:0]
  input  logic [1:0]  in_tuser,    // event_req [1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // data_byte [7:0], line_length [12:8], zero [15:13]
  output logic [2:0]  out_tuser,   // kind [2:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [tle_pkg::CFG_W-1:0] cap_r;
  logic                      cfg_wr;
  logic                      push, pop, q_full, q_empty, dump_done;
  tle_pkg::cmd_t             push_cmd, pop_cmd;
  tle_pkg::wr_req_t          wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == tle_pkg::REG_LINE_CAPACITY) ?
                      32'(cap_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= tle_pkg::CAP_RESET;
    end else if (cfg_wr && cfg_paddr[2] == tle_pkg::REG_LINE_CAPACITY) begin
      cap_r <= cfg_pwdata[tle_pkg::CFG_W-1:0];
    end
  end

  tle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cap       (cap_r),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .wr        (wr),
    .dump_done (dump_done)
  );

  tle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  tle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .pop        (pop),
    .q_cmd      (pop_cmd),
    .wr         (wr),
    .dump_done  (dump_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/tle_front.sv
module tle_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,
  input  logic [1:0]                 in_tuser,
  input  logic [tle_pkg::CFG_W-1:0]  cap,
  input  logic                       q_full,
  output logic                       push,
  output tle_pkg::cmd_t              push_cmd,
  output tle_pkg::wr_req_t           wr,
  input  logic                       dump_done
);

  logic [tle_pkg::IDX_W-1:0] fill_r, fill_nxt;
  logic                      pend_r, pend_nxt;
  logic                      accept;
  tle_pkg::event_t           ev;
  logic [tle_pkg::CFG_W-1:0] cap_lim;
  logic [tle_pkg::CFG_W-1:0] limit;
  logic [tle_pkg::CFG_W-1:0] fill_ext;
  logic [7:0]                c;

  assign in_tready = !pend_r && !q_full;
  assign accept    = in_tvalid && in_tready;
  assign ev        = tle_pkg::event_t'(in_tuser);
  assign c         = in_tdata;
  assign cap_lim   = (cap > tle_pkg::CFG_W'(tle_pkg::LINE_MAX)) ?
                     tle_pkg::CFG_W'(tle_pkg::LINE_MAX) : cap;
  assign limit     = cap_lim - tle_pkg::CFG_W'(1);
  assign fill_ext  = tle_pkg::CFG_W'(fill_r);

  always_comb begin
    fill_nxt = fill_r;
    pend_nxt = pend_r;
    push     = 1'b0;
    push_cmd = '0;
    wr       = '0;
    if (dump_done) begin
      pend_nxt = 1'b0;
    end
    if (accept && ev != tle_pkg::EV_NONE) begin
      if (cap < tle_pkg::CFG_W'(2) || ev == tle_pkg::EV_ERR) begin
        push        = 1'b1;
        push_cmd.op = tle_pkg::OP_FAIL;
        fill_nxt    = '0;
      end else if (ev == tle_pkg::EV_EOF) begin
        push = 1'b1;
        if (fill_r == '0) begin
          push_cmd.op = tle_pkg::OP_EMPTY;
        end else begin
          push_cmd.op  = tle_pkg::OP_DUMP;
          push_cmd.len = fill_r;
          fill_nxt     = '0;
          pend_nxt     = 1'b1;
        end
      end else begin
        unique case (c) inside
          tle_pkg::CH_CTRLC: begin
            push        = 1'b1;
            push_cmd.op = tle_pkg::OP_INTR;
            fill_nxt    = '0;
          end
          tle_pkg::CH_LF, tle_pkg::CH_CR: begin
            push         = 1'b1;
            push_cmd.op  = tle_pkg::OP_DUMP;
            push_cmd.nl  = 1'b1;
            push_cmd.len = fill_r;
            fill_nxt     = '0;
            pend_nxt     = 1'b1;
          end
          tle_pkg::CH_BS, tle_pkg::CH_DEL: begin
            if (fill_r != '0) begin
              push        = 1'b1;
              push_cmd.op = tle_pkg::OP_ERASE;
              fill_nxt    = fill_r - tle_pkg::IDX_W'(1);
            end
          end
          default: begin
            if (c >= tle_pkg::CH_SPACE && fill_ext < limit) begin
              push          = 1'b1;
              push_cmd.op   = tle_pkg::OP_ECHO;
              push_cmd.data = c;
              wr.en         = 1'b1;
              wr.addr       = fill_r;
              wr.data       = c;
              fill_nxt      = fill_r + tle_pkg::IDX_W'(1);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      pend_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

FILE: rtl/tle_queue.sv
module tle_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tle_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tle_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);

  tle_pkg::cmd_t              q_r [tle_pkg::QDEPTH];
  logic [tle_pkg::QPTR_W-1:0] wptr_r, rptr_r;
  logic [tle_pkg::QPTR_W:0]   cnt_r;
  logic                       do_push, do_pop;

  assign full    = cnt_r == (tle_pkg::QPTR_W + 1)'(tle_pkg::QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= wptr_r + tle_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_r <= rptr_r + tle_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + (tle_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - (tle_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

FILE: rtl/tle_back.sv
`include "terminal_line_editor_defines.svh"

module tle_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  output logic             pop,
  input  tle_pkg::cmd_t    q_cmd,
  input  tle_pkg::wr_req_t wr,
  output logic             dump_done,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,   // data_byte [7:0], line_length [12:8], zero [15:13]
  output logic [2:0]       out_tuser,   // kind [2:0]
  output logic             out_tlast
);

  tle_pkg::bstate_t          state_r, state_nxt;
  tle_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [1:0]                step_r, step_nxt;
  logic [tle_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]                mem [tle_pkg::LINE_MAX];
  logic [7:0]                rd_data_r;

  logic                      out_valid_r, out_valid_nxt;
  tle_pkg::kind_t            out_kind_r, out_kind_nxt;
  logic [7:0]                out_byte_r, out_byte_nxt;
  logic [tle_pkg::LEN_W-1:0] out_len_r, out_len_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      can_load;

  assign can_load   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {3'b000, out_len_r, out_byte_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    pop           = 1'b0;
    dump_done     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_len_nxt   = out_len_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      tle_pkg::B_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          cmd_nxt  = q_cmd;
          step_nxt = '0;
          idx_nxt  = '0;
          if (q_cmd.op == tle_pkg::OP_DUMP && !q_cmd.nl) begin
            state_nxt = (q_cmd.len == '0) ? tle_pkg::B_DONE : tle_pkg::B_CHAR;
          end else begin
            state_nxt = tle_pkg::B_RUN;
          end
        end
      end
      tle_pkg::B_RUN: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tle_pkg::K_ECHO;
          out_byte_nxt  = '0;
          out_len_nxt   = '0;
          out_last_nxt  = 1'b0;
          step_nxt      = step_r + 2'd1;
          unique case (cmd_r.op)
            tle_pkg::OP_ECHO: begin
              out_byte_nxt = cmd_r.data;
              out_last_nxt = 1'b1;
              state_nxt    = tle_pkg::B_IDLE;
            end
            tle_pkg::OP_ERASE: begin
              out_byte_nxt = (step_r == 2'd1) ? tle_pkg::CH_SPACE : tle_pkg::CH_BS;
              if (step_r == 2'd2) begin
                out_last_nxt = 1'b1;
                state_nxt    = tle_pkg::B_IDLE;
              end
            end
            tle_pkg::OP_INTR: begin
              if (step_r == 2'd0) begin
                out_byte_nxt = tle_pkg::CH_CARET;
              end else if (step_r == 2'd1) begin
                out_byte_nxt = tle_pkg::CH_UC_C;
              end else if (step_r == 2'd2) begin
                out_byte_nxt = tle_pkg::CH_LF;
              end else begin
                out_kind_nxt = tle_pkg::K_INTR;
                out_last_nxt = 1'b1;
                state_nxt    = tle_pkg::B_IDLE;
              end
            end
            tle_pkg::OP_EMPTY: begin
              out_kind_nxt = tle_pkg::K_EMPTY;
              out_last_nxt = 1'b1;
              state_nxt    = tle_pkg::B_IDLE;
            end
            tle_pkg::OP_DUMP: begin
              out_byte_nxt = tle_pkg::CH_LF;
              idx_nxt      = '0;
              state_nxt    = (cmd_r.len == '0) ? tle_pkg::B_DONE : tle_pkg::B_CHAR;
            end
            default: begin
              out_kind_nxt = tle_pkg::K_FAIL;
              out_last_nxt = 1'b1;
              state_nxt    = tle_pkg::B_IDLE;
            end
          endcase
        end
      end
      tle_pkg::B_CHAR: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tle_pkg::K_CHAR;
          out_byte_nxt  = rd_data_r;
          out_len_nxt   = tle_pkg::LEN_W'(idx_r);
          out_last_nxt  = 1'b0;
          if (idx_r == cmd_r.len - tle_pkg::IDX_W'(1)) begin
            state_nxt = tle_pkg::B_DONE;
          end else begin
            idx_nxt = idx_r + tle_pkg::IDX_W'(1);
          end
        end
      end
      tle_pkg::B_DONE: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = tle_pkg::K_DONE;
          out_byte_nxt  = '0;
          out_len_nxt   = tle_pkg::LEN_W'(cmd_r.len);
          out_last_nxt  = 1'b1;
          dump_done     = 1'b1;
          state_nxt     = tle_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = tle_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tle_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    step_r     <= step_nxt;
    idx_r      <= idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_len_r  <= out_len_nxt;
    out_last_r <= out_last_nxt;
  end

  `TLE_ASSERT_NOW(a_no_write_in_dump, wr.en, state_r != tle_pkg::B_CHAR, "store written during line dump")
  `TLE_ASSERT_NOW(a_idx_in_line, state_r == tle_pkg::B_CHAR, idx_r < cmd_r.len, "dump index past line length")
  `TLE_ASSERT_NOW(a_idle_holds_last, state_r == tle_pkg::B_IDLE && out_valid_r, out_last_r, "idle with a non-final beat pending")
  `TLE_ASSERT_NEXT(a_pop_starts, pop, state_r != tle_pkg::B_IDLE, "command popped but sequencer stayed idle")

endmodule
